// ----- rtl/smsort_pkg.sv -----
// Shared constants and types for the switch point merge sorter.
package smsort_pkg;

  localparam int MAX_POINTS = 64;
  localparam int X_BITS     = 16;
  localparam int KEY_W      = X_BITS + 1;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int FLUSH_W    = $clog2(MAX_POINTS);

  typedef logic [KEY_W-1:0] key_t;

  typedef struct packed {
    logic valid;
    key_t key;
  } slot_t;

  typedef struct packed {
    logic [15:0] in_x_pos;
    logic        in_state;
    logic        in_last;
  } in_t;

  typedef struct packed {
    logic [15:0] out_x_pos;
    logic        out_state;
    logic        out_last;
    logic        out_overflow;
  } out_t;

  typedef enum logic [1:0] {
    ST_INSERT,
    ST_FLUSH,
    ST_DRAIN
  } state_t;

endpackage

// ----- rtl/smsort_cell.sv -----
// One sorting cell: keeps the smaller key and passes the larger one to the right.
module smsort_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                shift,
  input  smsort_pkg::slot_t   carry_in,
  input  smsort_pkg::slot_t   right,
  output smsort_pkg::slot_t   held,
  output smsort_pkg::slot_t   carry_out
);

  smsort_pkg::slot_t held_next;
  smsort_pkg::slot_t carry_next;

  always_comb begin
    held_next        = held;
    carry_next       = carry_in;
    carry_next.valid = 1'b0;
    if (shift) begin
      held_next = right;
    end else if (carry_in.valid) begin
      if (!held.valid) begin
        held_next = carry_in;
      end else if (carry_in.key < held.key) begin
        held_next  = carry_in;
        carry_next = held;
      end else begin
        carry_next = carry_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held.valid      <= 1'b0;
      carry_out.valid <= 1'b0;
    end else begin
      held      <= held_next;
      carry_out <= carry_next;
    end
  end

endmodule

// ----- rtl/switch_point_merge_sorter.sv -----
// Top level of the switch point merge sorter: a chain of sorting cells and its control.
// Points are accepted one per cycle while a batch is collected.
// After the last point is accepted, a flush state lets keys settle in the cell chain,
// then the sorted batch drains one result per cycle from the first cell while res_ready allows.
// No point is accepted from the last point of a batch until its final result is loaded.
// Reset (rst, synchronous) empties all cells and the output register.
module switch_point_merge_sorter (
  input  logic              clk,
  input  logic              rst,
  input  logic              pt_valid,
  output logic              pt_ready,
  input  smsort_pkg::in_t   pt,
  output logic              res_valid,
  input  logic              res_ready,
  output smsort_pkg::out_t  res
);

  smsort_pkg::state_t state;
  smsort_pkg::state_t state_next;

  logic [smsort_pkg::CNT_W-1:0]   count;
  logic [smsort_pkg::FLUSH_W-1:0] flush_cnt;
  logic                           dropped;

  smsort_pkg::slot_t held  [smsort_pkg::MAX_POINTS];
  smsort_pkg::slot_t carry [smsort_pkg::MAX_POINTS];
  smsort_pkg::slot_t entry;
  smsort_pkg::slot_t empty_slot;

  logic accept;
  logic has_room;
  logic load;
  logic done;

  assign accept   = pt_valid && pt_ready;
  assign has_room = count < smsort_pkg::CNT_W'(smsort_pkg::MAX_POINTS);
  assign done     = load && !held[1].valid;

  always_comb begin
    entry.valid = accept && has_room;
    entry.key   = {pt.in_x_pos[smsort_pkg::X_BITS-1:0], pt.in_state};
    empty_slot  = entry;
    empty_slot.valid = 1'b0;
  end

  for (genvar i = 0; i < smsort_pkg::MAX_POINTS; i++) begin : g_cell
    smsort_pkg::slot_t cin;
    smsort_pkg::slot_t rgt;
    if (i == 0) begin : g_first
      assign cin = entry;
    end else begin : g_mid
      assign cin = carry[i-1];
    end
    if (i == smsort_pkg::MAX_POINTS - 1) begin : g_end
      assign rgt = empty_slot;
    end else begin : g_inner
      assign rgt = held[i+1];
    end
    smsort_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift     (load),
      .carry_in  (cin),
      .right     (rgt),
      .held      (held[i]),
      .carry_out (carry[i])
    );
  end

  always_comb begin
    state_next = state;
    unique case (state)
      smsort_pkg::ST_INSERT: begin
        if (accept && pt.in_last) begin
          state_next = smsort_pkg::ST_FLUSH;
        end
      end
      smsort_pkg::ST_FLUSH: begin
        if (flush_cnt == smsort_pkg::FLUSH_W'(smsort_pkg::MAX_POINTS - 1)) begin
          state_next = smsort_pkg::ST_DRAIN;
        end
      end
      smsort_pkg::ST_DRAIN: begin
        if (done) begin
          state_next = smsort_pkg::ST_INSERT;
        end
      end
      default: state_next = smsort_pkg::ST_INSERT;
    endcase
  end

  always_comb begin
    pt_ready = 1'b0;
    load     = 1'b0;
    unique case (state)
      smsort_pkg::ST_INSERT: pt_ready = 1'b1;
      smsort_pkg::ST_FLUSH:  pt_ready = 1'b0;
      smsort_pkg::ST_DRAIN:  load     = !res_valid || res_ready;
      default: begin
        pt_ready = 1'b0;
        load     = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= smsort_pkg::ST_INSERT;
      count     <= '0;
      flush_cnt <= '0;
      dropped   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (has_room) begin
          count <= count + 1'b1;
        end else begin
          dropped <= 1'b1;
        end
      end
      if (state == smsort_pkg::ST_FLUSH) begin
        flush_cnt <= flush_cnt + 1'b1;
      end else begin
        flush_cnt <= '0;
      end
      if (done) begin
        count   <= '0;
        dropped <= 1'b0;
      end
      if (load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res.out_x_pos    <= 16'(held[0].key[smsort_pkg::KEY_W-1:1]);
      res.out_state    <= held[0].key[0];
      res.out_last     <= !held[1].valid;
      res.out_overflow <= dropped;
    end
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the switch point merge sorter: random batches, sorted-order check.
module tb_top;

  localparam int IDLE_LIMIT    = 4000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 2 * smsort_pkg::MAX_POINTS + 32;
  localparam int RANDOM_POINTS = 220;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pt_valid = 1'b0;
  logic pt_ready;
  smsort_pkg::in_t  pt = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  smsort_pkg::out_t res;

  smsort_pkg::in_t  point_queue[$];
  smsort_pkg::out_t sorted_points[$];
  smsort_pkg::key_t batch_keys[$];
  logic batch_dropped = 1'b0;
  int   mismatches = 0;
  int   send_gap = 0;
  int   recv_gap = 0;
  logic send_calm = 1'b0;
  logic recv_calm = 1'b0;
  logic hold_off = 1'b0;
  int   idle_cycles = 0;

  switch_point_merge_sorter DUT (
    .clk       (clk),
    .rst       (rst),
    .pt_valid  (pt_valid),
    .pt_ready  (pt_ready),
    .pt        (pt),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic collect_point(input smsort_pkg::in_t p);
    smsort_pkg::key_t k;
    smsort_pkg::key_t sorted[$];
    smsort_pkg::out_t r;
    int               j;
    k = {p.in_x_pos[smsort_pkg::X_BITS-1:0], p.in_state};
    if (batch_keys.size() < smsort_pkg::MAX_POINTS) begin
      batch_keys.push_back(k);
    end else begin
      batch_dropped = 1'b1;
    end
    if (p.in_last) begin
      foreach (batch_keys[i]) begin
        j = sorted.size();
        while (j > 0 && sorted[j-1] > batch_keys[i]) j--;
        sorted.insert(j, batch_keys[i]);
      end
      foreach (sorted[i]) begin
        r.out_x_pos    = sorted[i][smsort_pkg::KEY_W-1:1];
        r.out_state    = sorted[i][0];
        r.out_last     = (i == sorted.size() - 1);
        r.out_overflow = batch_dropped;
        sorted_points.push_back(r);
      end
      batch_keys.delete();
      batch_dropped = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  task automatic add_point(input logic [15:0] x, input logic st, input logic last);
    smsort_pkg::in_t p;
    p.in_x_pos = x;
    p.in_state = st;
    p.in_last  = last;
    point_queue.push_back(p);
  endtask

  task automatic add_batch(input int n);
    int          spread;
    logic [15:0] x;
    spread = $urandom_range(0, 2);
    for (int i = 0; i < n; i++) begin
      case (spread)
        0: x = 16'($urandom_range(0, 7)) + 16'h7FFC;
        1: x = 16'($urandom);
        default: x = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'($urandom_range(0, 3));
      endcase
      add_point(x, 1'($urandom_range(0, 1)), i == n - 1);
    end
  endtask

  task automatic wait_drained();
    while (point_queue.size() > 0 || pt_valid || sorted_points.size() > 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pt_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (pt_valid && pt_ready) collect_point(pt);
      if (!pt_valid || pt_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          pt_valid <= 1'b0;
        end else if (point_queue.size() > 0) begin
          pt <= point_queue.pop_front();
          pt_valid <= 1'b1;
          if ($urandom_range(0, 15) == 0) send_calm <= !send_calm;
          send_gap <= send_calm ? 0 : $urandom_range(0, 6);
        end else begin
          pt_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    smsort_pkg::out_t want;
    int               gap;
    if (rst) begin
      res_ready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (res_valid && res_ready) begin
        if (sorted_points.size() == 0) begin
          report_mismatch("result with none pending", int'(res), 0);
        end else begin
          want = sorted_points.pop_front();
          if (res.out_x_pos !== want.out_x_pos)
            report_mismatch("out_x_pos", int'(res.out_x_pos), int'(want.out_x_pos));
          if (res.out_state !== want.out_state)
            report_mismatch("out_state", int'(res.out_state), int'(want.out_state));
          if (res.out_last !== want.out_last)
            report_mismatch("out_last", int'(res.out_last), int'(want.out_last));
          if (res.out_overflow !== want.out_overflow)
            report_mismatch("out_overflow", int'(res.out_overflow),
                            int'(want.out_overflow));
        end
      end
      if (hold_off) begin
        res_ready <= 1'b0;
      end else if (res_valid && res_ready) begin
        if ($urandom_range(0, 15) == 0) recv_calm <= !recv_calm;
        gap = recv_calm ? 0 : $urandom_range(0, 6);
        recv_gap <= gap;
        res_ready <= (gap == 0);
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        res_ready <= (recv_gap == 1);
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (pt_valid && pt_ready) || (res_valid && res_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("** switch_point_merge_sorter: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int n;
    int total;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Single-point batches at both ends of the x range.
    add_point(16'h0000, 1'b0, 1'b1);
    add_point(16'hFFFF, 1'b1, 1'b1);
    // Equal x with both states, duplicate keys and extremes in one batch.
    add_point(16'h0005, 1'b1, 1'b0);
    add_point(16'h0005, 1'b0, 1'b0);
    add_point(16'hFFFF, 1'b0, 1'b0);
    add_point(16'h0000, 1'b1, 1'b0);
    add_point(16'h0005, 1'b1, 1'b0);
    add_point(16'h0000, 1'b0, 1'b0);
    add_point(16'hFFFF, 1'b1, 1'b0);
    add_point(16'h8000, 1'b0, 1'b0);
    add_point(16'h7FFF, 1'b1, 1'b0);
    add_point(16'h0005, 1'b0, 1'b1);
    // Points arriving in descending order.
    add_point(16'h0040, 1'b1, 1'b0);
    add_point(16'h0030, 1'b0, 1'b0);
    add_point(16'h0020, 1'b1, 1'b0);
    add_point(16'h0010, 1'b0, 1'b1);
    // Alternating bit patterns.
    add_point(16'hAAAA, 1'b0, 1'b0);
    add_point(16'hAAAA, 1'b0, 1'b0);
    add_point(16'h5555, 1'b1, 1'b1);
    wait_drained();

    // A full batch and an overflowing batch whose last point is dropped sit among
    // random small batches.
    total = 0;
    for (int b = 0; total < RANDOM_POINTS || b <= 12; b++) begin
      if (b == 4) n = smsort_pkg::MAX_POINTS;
      else if (b == 12) n = smsort_pkg::MAX_POINTS + 2;
      else if ($urandom_range(0, 7) == 0) n = $urandom_range(9, 40);
      else n = $urandom_range(1, 8);
      add_batch(n);
      total += n;
    end

    // The receiver holds off while the sender keeps offering points.
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("** switch_point_merge_sorter: PASSED **");
    end else begin
      $display("** switch_point_merge_sorter: FAILED **");
    end
    $finish;
  end

endmodule
